@@ rtl/sorted_unique_block_set_top_macros.svh @@
// ============================================================================
// sorted_unique_block_set_top_macros.svh
// Assertion macros used by the sorted block set engine. Defining
// NO_ASSERTIONS turns every use into nothing.
// ============================================================================
`ifndef SORTED_UNIQUE_BLOCK_SET_TOP_MACROS_SVH
`define SORTED_UNIQUE_BLOCK_SET_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property that must hold at every clock edge out of reset
`define SOBS_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("sorted block set: assertion failed");

// Same-cycle implication
`define SOBS_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sorted block set: implication failed");

// Next-cycle implication
`define SOBS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sorted block set: next-cycle implication failed");

`else

`define SOBS_ASSERT(label, clk, rstn, prop)
`define SOBS_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define SOBS_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

@@ rtl/sobs_pkg.sv @@
// ============================================================================
// sobs_pkg
// Types and constants shared by the sorted block set modules.
// ============================================================================
`default_nettype none

package sobs_pkg;

    // Field widths of the words on the channels
    localparam int DATA_W        = 32;
    localparam int STATUS_W      = 2;
    localparam int ENTRY_COUNT_W = 11;
    localparam int SLOT_W        = 10;

    // Default table capacity
    localparam int DEF_CAPACITY  = 1024;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 2'd0,
        ST_PRESENT  = 2'd1,
        ST_BEYOND   = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    // One result word
    typedef struct packed {
        status_t                  status;
        logic [ENTRY_COUNT_W-1:0] entry_count;
        logic [SLOT_W-1:0]        slot;
    } result_t;

    // Sequencer states of the table engine
    typedef enum logic [2:0] {
        ES_IDLE,
        ES_LAST,
        ES_PROBE,
        ES_DECIDE,
        ES_SHIFT,
        ES_PLACE,
        ES_DONE
    } engine_state_t;

endpackage

`default_nettype wire

@@ rtl/sobs_ram.sv @@
// ============================================================================
// sobs_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data. A read of the address being written in the same cycle returns
// the old contents.
// ============================================================================
`default_nettype none

module sobs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ rtl/sobs_engine.sv @@
// ============================================================================
// sobs_engine
// Table sequencer: checks a block number against the device size and the
// largest entry, binary-searches the table RAM, and shifts larger entries up
// by one slot before placing a new number. Holds the entry count.
// ============================================================================
`default_nettype none

`include "sorted_unique_block_set_top_macros.svh"

module sobs_engine #(
    parameter int CAPACITY = sobs_pkg::DEF_CAPACITY
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic [sobs_pkg::DATA_W-1:0] dev_blocks,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [sobs_pkg::DATA_W-1:0] in_block_number,
    output logic                             res_valid,
    input  wire logic                        res_ready,
    output sobs_pkg::result_t                res
);

    import sobs_pkg::*;

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    engine_state_t       state_reg, state_next;
    logic [DATA_W-1:0]   value_reg, value_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [ADDR_W-1:0]   lo_reg, lo_next;
    logic [ADDR_W-1:0]   hi_reg, hi_next;
    logic [ADDR_W-1:0]   mid_reg, mid_next;
    logic                hit_reg, hit_next;
    logic [ADDR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    status_t             status_reg, status_next;
    logic [ADDR_W-1:0]   slot_reg, slot_next;

    // RAM port
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [DATA_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [DATA_W-1:0]   rd_data;

    // Shared decode
    logic                in_accept;
    logic                beyond;
    logic                full;
    logic [CNT_W-1:0]    count_m1;
    logic [ADDR_W-1:0]   last_hi;
    logic                last_go;
    logic                rd_eq;
    logic                rd_lt;
    logic [ADDR_W-1:0]   probe_lo;
    logic [ADDR_W-1:0]   probe_hi;
    logic                probe_hit;
    logic                probe_go;
    logic [ADDR_W-1:0]   probe_mid;
    logic [ADDR_W-1:0]   wr_dec;
    logic                shift_go;

    sobs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (rd_data)
    );

    assign in_ready  = (state_reg == ES_IDLE);
    assign in_accept = in_valid && in_ready;
    assign beyond    = (in_block_number >= dev_blocks);
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign count_m1  = count_reg - CNT_W'(1);
    assign last_hi   = count_m1[ADDR_W-1:0];
    assign last_go   = (last_hi != '0);

    // Compare the word just read against the offered number
    assign rd_eq = (rd_data == value_reg);
    assign rd_lt = (rd_data < value_reg);

    // One lower-bound search step; next probe issued in the same cycle
    assign probe_lo  = rd_lt ? (mid_reg + ADDR_W'(1)) : lo_reg;
    assign probe_hi  = rd_lt ? hi_reg : mid_reg;
    assign probe_hit = hit_reg || rd_eq;
    assign probe_go  = (probe_lo < probe_hi);
    assign probe_mid = probe_lo + ((probe_hi - probe_lo) >> 1);

    // Shift pointer
    assign wr_dec   = wr_ptr_reg - ADDR_W'(1);
    assign shift_go = (wr_dec > lo_reg);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ES_IDLE: begin
                if (in_accept) begin
                    state_next = (beyond || (count_reg == '0)) ? ES_DONE : ES_LAST;
                end
            end
            ES_LAST: begin
                if (rd_eq || rd_lt) begin
                    state_next = ES_DONE;
                end else begin
                    state_next = last_go ? ES_PROBE : ES_DECIDE;
                end
            end
            ES_PROBE: begin
                state_next = probe_go ? ES_PROBE : ES_DECIDE;
            end
            ES_DECIDE: begin
                state_next = (hit_reg || full) ? ES_DONE : ES_SHIFT;
            end
            ES_SHIFT: begin
                state_next = shift_go ? ES_SHIFT : ES_PLACE;
            end
            ES_PLACE: begin
                state_next = ES_DONE;
            end
            ES_DONE: begin
                if (res_ready) begin
                    state_next = ES_IDLE;
                end
            end
            default: begin
                state_next = ES_IDLE;
            end
        endcase
    end

    // Datapath and RAM control
    always_comb begin
        value_next  = value_reg;
        count_next  = count_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        hit_next    = hit_reg;
        wr_ptr_next = wr_ptr_reg;
        status_next = status_reg;
        slot_next   = slot_reg;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = value_reg;
        ram_re      = 1'b0;
        ram_raddr   = '0;
        res_valid   = 1'b0;
        case (state_reg)
            ES_IDLE: begin
                if (in_accept) begin
                    value_next = in_block_number;
                    slot_next  = '0;
                    if (beyond) begin
                        status_next = ST_BEYOND;
                    end else if (count_reg == '0) begin
                        // empty table: place at slot zero
                        ram_we      = 1'b1;
                        ram_waddr   = '0;
                        ram_wdata   = in_block_number;
                        count_next  = count_reg + CNT_W'(1);
                        status_next = ST_INSERTED;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = last_hi;
                    end
                end
            end
            ES_LAST: begin
                if (rd_eq) begin
                    status_next = ST_PRESENT;
                    slot_next   = '0;
                end else if (rd_lt) begin
                    // larger than every entry: append
                    if (full) begin
                        status_next = ST_FULL;
                        slot_next   = '0;
                    end else begin
                        ram_we      = 1'b1;
                        ram_waddr   = count_reg[ADDR_W-1:0];
                        count_next  = count_reg + CNT_W'(1);
                        status_next = ST_INSERTED;
                        slot_next   = count_reg[ADDR_W-1:0];
                    end
                end else begin
                    // search slots below the last one
                    lo_next  = '0;
                    hi_next  = last_hi;
                    hit_next = 1'b0;
                    if (last_go) begin
                        mid_next  = last_hi >> 1;
                        ram_re    = 1'b1;
                        ram_raddr = last_hi >> 1;
                    end
                end
            end
            ES_PROBE: begin
                lo_next  = probe_lo;
                hi_next  = probe_hi;
                hit_next = probe_hit;
                if (probe_go) begin
                    mid_next  = probe_mid;
                    ram_re    = 1'b1;
                    ram_raddr = probe_mid;
                end
            end
            ES_DECIDE: begin
                slot_next = '0;
                if (hit_reg) begin
                    status_next = ST_PRESENT;
                end else if (full) begin
                    status_next = ST_FULL;
                end else begin
                    // start moving entries lo..count-1 up by one
                    wr_ptr_next = count_reg[ADDR_W-1:0];
                    ram_re      = 1'b1;
                    ram_raddr   = last_hi;
                end
            end
            ES_SHIFT: begin
                ram_we      = 1'b1;
                ram_waddr   = wr_ptr_reg;
                ram_wdata   = rd_data;
                wr_ptr_next = wr_dec;
                if (shift_go) begin
                    ram_re    = 1'b1;
                    ram_raddr = wr_dec - ADDR_W'(1);
                end
            end
            ES_PLACE: begin
                ram_we      = 1'b1;
                ram_waddr   = lo_reg;
                ram_wdata   = value_reg;
                count_next  = count_reg + CNT_W'(1);
                status_next = ST_INSERTED;
                slot_next   = lo_reg;
            end
            ES_DONE: begin
                res_valid = 1'b1;
            end
            default: begin
                res_valid = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ES_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        value_reg  <= value_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        hit_reg    <= hit_next;
        wr_ptr_reg <= wr_ptr_next;
        status_reg <= status_next;
        slot_reg   <= slot_next;
    end

    // Result word
    assign res.status      = status_reg;
    assign res.entry_count = ENTRY_COUNT_W'(count_reg);
    assign res.slot        = SLOT_W'(slot_reg);

    // Assertions
    `SOBS_ASSERT(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(CAPACITY))
    `SOBS_ASSERT_IMPL(a_shift_no_overlap, aclk, aresetn, (state_reg == ES_SHIFT) && ram_re, ram_raddr != ram_waddr)
    `SOBS_ASSERT_IMPL(a_write_states, aclk, aresetn, ram_we, (state_reg == ES_IDLE) || (state_reg == ES_LAST) || (state_reg == ES_SHIFT) || (state_reg == ES_PLACE))
    `SOBS_ASSERT_NEXT(a_place_done, aclk, aresetn, state_reg == ES_PLACE, (state_reg == ES_DONE) && (status_reg == ST_INSERTED) && (count_reg == $past(count_reg) + CNT_W'(1)))
    `SOBS_ASSERT_IMPL(a_slot_zero, aclk, aresetn, res_valid && (status_reg != ST_INSERTED), slot_reg == '0)

endmodule

`default_nettype wire

@@ rtl/sorted_unique_block_set_top.sv @@
// ============================================================================
// sorted_unique_block_set_top
// Sorted set of distinct block numbers with a fixed-capacity table.
// ============================================================================
// Usage:
//   cfg_wr_en/cfg_wr_data write the device size (in blocks), reset value 0,
//   while the block is idle. Numbers at or above it are reported as beyond.
//   The s_ channel carries one block number per word; the m_ channel returns
//   one result word per input: status, entry count after the item, and the
//   slot where the number was placed (0 unless inserted).
//   Beyond-device numbers and the empty table are settled at accept; other
//   numbers are first compared with the largest entry, which settles a
//   duplicate of it or an append (or full); numbers below it are found by a
//   binary search of the lower slots, and on an insert the larger entries
//   are shifted up one by one before the number is placed. Search probes
//   and shifted entries share the single read and single write port of the
//   table RAM; one item is in work at a time. An output register holds a
//   finished result, so the next word is accepted while the receiver
//   stalls; its result then waits in the engine.
//   Reset empties the table at once (count cleared, no memory sweep) and
//   sets the device size to 0.
// ============================================================================
`default_nettype none

module sorted_unique_block_set_top #(
    parameter int CAPACITY = sobs_pkg::DEF_CAPACITY
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wr_en,
    input  wire logic [sobs_pkg::DATA_W-1:0]        cfg_wr_data,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [sobs_pkg::DATA_W-1:0]        s_block_number,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [sobs_pkg::STATUS_W-1:0]           m_status,
    output logic [sobs_pkg::ENTRY_COUNT_W-1:0]      m_entry_count,
    output logic [sobs_pkg::SLOT_W-1:0]             m_slot
);

    import sobs_pkg::*;

    logic [DATA_W-1:0] dev_blocks_reg;
    logic              out_valid_reg, out_valid_next;
    result_t           out_word_reg;
    logic              res_valid;
    logic              res_ready;
    result_t           res;

    // Device size register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_blocks_reg <= '0;
        end else if (cfg_wr_en) begin
            dev_blocks_reg <= cfg_wr_data;
        end
    end

    sobs_engine #(
        .CAPACITY (CAPACITY)
    ) u_engine (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .dev_blocks      (dev_blocks_reg),
        .in_valid        (s_valid),
        .in_ready        (s_ready),
        .in_block_number (s_block_number),
        .res_valid       (res_valid),
        .res_ready       (res_ready),
        .res             (res)
    );

    // Output register: loads when empty or being drained
    assign res_ready = !out_valid_reg || m_ready;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (res_ready) begin
            out_valid_next = res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            out_word_reg <= res;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_status      = out_word_reg.status;
    assign m_entry_count = out_word_reg.entry_count;
    assign m_slot        = out_word_reg.slot;

endmodule

`default_nettype wire
